@@ src/fpa_pkg.sv @@
// Shared constants, op codes and types for the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int W         = 32;
    localparam int QW        = W + FRAC_BITS;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_I2F  = 3'd4;
    localparam logic [2:0] OP_F2I  = 3'd5;
    localparam logic [2:0] OP_F2U  = 3'd6;

    typedef struct packed {
        logic [2:0]   op;
        logic [W-1:0] res;
        logic         flag;
    } side_t;

endpackage

@@ src/fpa_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module fpa_divider
    import fpa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [QW-1:0] dvd,
    input  logic [W-1:0]  dvs,
    input  logic          neg,
    input  side_t         side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          neg_out,
    output side_t         side_out
);

    logic          v_s    [QW+1];
    logic [QW-1:0] dq_s   [QW+1];
    logic [W-1:0]  rem_s  [QW+1];
    logic [W-1:0]  dvs_s  [QW+1];
    logic          neg_s  [QW+1];
    side_t         side_s [QW+1];

    assign v_s[0]    = in_valid;
    assign dq_s[0]   = dvd;
    assign rem_s[0]  = '0;
    assign dvs_s[0]  = dvs;
    assign neg_s[0]  = neg;
    assign side_s[0] = side_in;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [W:0]    trial;
        logic [W+1:0]  diff;
        logic          ge;
        logic          v_reg;
        logic [QW-1:0] dq_reg;
        logic [W-1:0]  rem_reg;
        logic [W-1:0]  dvs_reg;
        logic          neg_reg;
        side_t         side_reg;

        assign trial = {rem_s[i], dq_s[i][QW-1]};
        assign diff  = {1'b0, trial} - {2'b00, dvs_s[i]};
        assign ge    = !diff[W+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg   <= {dq_s[i][QW-2:0], ge};
                rem_reg  <= ge ? diff[W-1:0] : trial[W-1:0];
                dvs_reg  <= dvs_s[i];
                neg_reg  <= neg_s[i];
                side_reg <= side_s[i];
            end
        end

        assign v_s[i+1]    = v_reg;
        assign dq_s[i+1]   = dq_reg;
        assign rem_s[i+1]  = rem_reg;
        assign dvs_s[i+1]  = dvs_reg;
        assign neg_s[i+1]  = neg_reg;
        assign side_s[i+1] = side_reg;
    end

    assign out_valid = v_s[QW];
    assign quo       = dq_s[QW];
    assign neg_out   = neg_s[QW];
    assign side_out  = side_s[QW];

endmodule

@@ src/fixed_point_alu.sv @@
// Top level of the pipelined Q-format fixed-point ALU.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------
//  req     | req_valid | req_stall | op, operand_a, operand_b
//  rsp     | rsp_valid | rsp_stall | result, div_by_zero
//
// One word enters per cycle while req_stall is low; every op walks the
// divider's one-bit-per-stage pipeline, carrying its other results as sideband.
// rst_n clears only the valid bits; payload registers hold whatever they had.
// A stalled output word freezes the whole pipeline; req_stall follows it, so
// nothing is dropped or repeated.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [2:0]          op,
    input  logic signed [W-1:0] operand_a,
    input  logic signed [W-1:0] operand_b,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic signed [W-1:0] result,
    output logic                div_by_zero
);

    logic en;

    logic                s1_valid_reg;
    logic [2:0]          s1_op_reg;
    logic signed [W-1:0] s1_a_reg;
    logic signed [W-1:0] s1_b_reg;

    logic                  s2_valid_reg;
    logic [2:0]            s2_op_reg;
    logic signed [2*W-1:0] s2_prod_reg;
    logic [W-1:0]          s2_simple_reg;
    logic [QW-1:0]         s2_dvd_reg;
    logic [W-1:0]          s2_dvs_reg;
    logic                  s2_neg_reg;
    logic                  s2_flag_reg;

    logic                  rsp_valid_reg;
    logic [W-1:0]          result_reg;
    logic                  dbz_reg;

    logic signed [2*W-1:0] prod_next;
    logic [W-1:0]          a_mag;
    logic [W-1:0]          b_mag;
    logic signed [W-1:0]   a_shr;
    logic [W-1:0]          f2i;
    logic [W-1:0]          simple_next;

    side_t         side_in;
    side_t         side_out;
    logic          dv_valid;
    logic [QW-1:0] dv_quo;
    logic          dv_neg;
    logic [W-1:0]  q_low;
    logic [W-1:0]  result_next;

    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !en;

    assign prod_next = s1_a_reg * s1_b_reg;
    assign a_mag     = s1_a_reg[W-1] ? (~s1_a_reg + 1'b1) : s1_a_reg;
    assign b_mag     = s1_b_reg[W-1] ? (~s1_b_reg + 1'b1) : s1_b_reg;
    assign a_shr     = s1_a_reg >>> FRAC_BITS;
    assign f2i       = a_shr + {{(W-1){1'b0}},
                       (s1_a_reg[W-1] && (|s1_a_reg[FRAC_BITS-1:0]))};

    always_comb
    begin
        case (s1_op_reg)
            OP_ADD:  simple_next = s1_a_reg + s1_b_reg;
            OP_SUB:  simple_next = s1_a_reg - s1_b_reg;
            OP_I2F:  simple_next = s1_a_reg << FRAC_BITS;
            OP_F2I:  simple_next = f2i;
            OP_F2U:  simple_next = a_shr;
            default: simple_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg     <= op;
            s1_a_reg      <= operand_a;
            s1_b_reg      <= operand_b;
            s2_op_reg     <= s1_op_reg;
            s2_prod_reg   <= prod_next;
            s2_simple_reg <= simple_next;
            s2_dvd_reg    <= {a_mag, {FRAC_BITS{1'b0}}};
            s2_dvs_reg    <= b_mag;
            s2_neg_reg    <= s1_a_reg[W-1] ^ s1_b_reg[W-1];
            s2_flag_reg   <= (s1_op_reg == OP_DIV) && (s1_b_reg == '0);
            result_reg    <= result_next;
            dbz_reg       <= side_out.flag;
        end
    end

    // arithmetic shift of the product is a fixed slice
    always_comb
    begin
        side_in.op   = s2_op_reg;
        side_in.flag = s2_flag_reg;
        side_in.res  = (s2_op_reg == OP_MUL) ? s2_prod_reg[FRAC_BITS+W-1:FRAC_BITS]
                                             : s2_simple_reg;
    end

    fpa_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .dvd       (s2_dvd_reg),
        .dvs       (s2_dvs_reg),
        .neg       (s2_neg_reg),
        .side_in   (side_in),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .neg_out   (dv_neg),
        .side_out  (side_out)
    );

    assign q_low = dv_neg ? (~dv_quo[W-1:0] + 1'b1) : dv_quo[W-1:0];

    always_comb
    begin
        if (side_out.op == OP_DIV)
        begin
            result_next = side_out.flag ? '0 : q_low;
        end
        else
        begin
            result_next = side_out.res;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign result      = result_reg;
    assign div_by_zero = dbz_reg;

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && div_by_zero |-> result == '0)
        else $error("divide by zero word with nonzero result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && req_stall |=> s1_valid_reg)
        else $error("stalled pipeline lost a word");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled without output back-pressure");

endmodule
